// File: src/nbc_pkg.sv
// shared constants for the byte-level naive bayes classifier
`timescale 1ns / 1ps
package nbc_pkg;
	localparam int ACC_W          = 48;
	localparam int TOT_W          = 32;
	localparam int CHAR_W         = 8;
	localparam int CHAR_N         = 256;
	localparam int COUNT_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 24;

	// command codes
	localparam logic CMD_TRAIN = 1'b0;
	localparam logic CMD_SCORE = 1'b1;
endpackage

// File: src/nbc_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module nbc_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: src/nbc_mul.sv
// iterative shift-add multiplier, one operand bit per cycle
`timescale 1ns / 1ps
module nbc_mul #(
	parameter int W = nbc_pkg::ACC_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] prod
);
	import nbc_pkg::*;
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     a_q, hi_q, lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [W:0]       sum;

	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
	assign done = done_q;
	assign prod = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			lo_q <= b;
			hi_q <= '0;
		end else if (busy_q) begin
			{hi_q, lo_q} <= {sum, lo_q[W-1:1]};
		end
	end
endmodule

// File: src/nbc_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module nbc_div #(
	parameter int NUM_W = 81,
	parameter int DEN_W = 57
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	import nbc_pkg::*;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   trial, diff;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign done  = done_q;
	assign quot  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end
endmodule

// File: src/char_naive_bayes_classifier.sv
// top level: two-class byte naive bayes trainer and scorer
`timescale 1ns / 1ps
// a training word is accepted, then its table entry is read, incremented and written back
// a scoring word runs, per class, up to two multiplies, a divide and a multiply, the divide
// NUM_W = COUNT_BITS+33+FRAC_BITS bits wide, plus a prior divide per class on a name's first
// byte when the model is not empty; all of these go through the shared bit-serial mul and div
// one word at a time; output register lets the next word in while a result waits
// reset (async, active low) clears totals, scores, flags and the count valid bits
module char_naive_bayes_classifier #(
	parameter int COUNT_BITS = nbc_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = nbc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [nbc_pkg::CHAR_W-1:0]    s_axis_tdata,  // char_code
	input  logic [1:0]                    s_axis_tuser,  // command, is_male
	input  logic                          s_axis_tlast,  // last_char
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [2*nbc_pkg::ACC_W-1:0]   m_axis_tdata,  // male_score, female_score
	output logic                          m_axis_tuser   // saturated
);
	import nbc_pkg::*;

	localparam int CW    = COUNT_BITS;
	localparam int NW    = TOT_W + 1;               // class sum n
	localparam int PW    = CW + 1;                  // c + o
	localparam int NUM_W = CW + NW + FRAC_BITS;     // c*n scaled
	localparam int DEN_W = CW + NW;                 // own_total*(c+o)
	localparam int AW    = $clog2(CHAR_N);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_BEGIN = 4'd2;
	localparam logic [3:0] S_PDIV  = 4'd3;
	localparam logic [3:0] S_FACT  = 4'd4;
	localparam logic [3:0] S_M1    = 4'd5;
	localparam logic [3:0] S_M2    = 4'd6;
	localparam logic [3:0] S_FDIV  = 4'd7;
	localparam logic [3:0] S_APP   = 4'd8;
	localparam logic [3:0] S_NEXT  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [ACC_W-1:0] ONE     = ACC_W'(1) << FRAC_BITS;

	logic [3:0]        state_q;
	logic              cmd_q, male_q, last_q;
	logic [AW-1:0]     char_q;
	logic [CHAR_N-1:0] vld_q;                       // count entry written since reset
	logic [TOT_W-1:0]  mt_q, ft_q;
	logic [ACC_W-1:0]  macc_q, facc_q;
	logic              open_q, sat_q;
	logic [CW-1:0]     mc_q, fc_q;
	logic [NW-1:0]     n_q;
	logic              cls_q;                       // 0 male, 1 female
	logic [NUM_W-1:0]  num_hold_q;

	logic              mul_go_q, div_go_q;
	logic [ACC_W-1:0]  mul_a_q, mul_b_q;
	logic [NUM_W-1:0]  div_num_q;
	logic [DEN_W-1:0]  div_den_q;
	logic              mul_done, div_done;
	logic [2*ACC_W-1:0] mul_prod;
	logic [NUM_W-1:0]  div_quot;

	logic              out_valid_q, out_sat_q;
	logic [2*ACC_W-1:0] out_data_q;

	// count table: {male, female} per byte
	logic              ram_we;
	logic [2*CW-1:0]   ram_wdata, ram_rdata;
	logic [CW-1:0]     cur_m, cur_f, cnt_sel, cnt_new;
	logic              cnt_full;
	logic [TOT_W-1:0]  tot_sel;
	logic              tot_full;

	// per-class operand selection
	logic [CW-1:0]     c_sel, o_sel;
	logic [TOT_W-1:0]  own_sel;
	logic [ACC_W-1:0]  acc_sel;
	logic [PW-1:0]     cpo;
	logic [NW+1:0]     n3;
	logic [CW+3:0]     o10;
	logic              fsat, psat;
	logic [ACC_W-1:0]  fval, pval;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

	// entries never written read as zero
	assign cur_m    = vld_q[char_q] ? ram_rdata[2*CW-1:CW] : '0;
	assign cur_f    = vld_q[char_q] ? ram_rdata[CW-1:0] : '0;
	assign cnt_sel  = male_q ? cur_m : cur_f;
	assign cnt_full = (cnt_sel == {CW{1'b1}});
	assign cnt_new  = cnt_full ? cnt_sel : cnt_sel + 1'b1;
	assign tot_sel  = male_q ? mt_q : ft_q;
	assign tot_full = (tot_sel == {TOT_W{1'b1}});
	assign ram_we    = (state_q == S_RD) && (cmd_q == CMD_TRAIN);
	assign ram_wdata = male_q ? {cnt_new, cur_f} : {cur_m, cnt_new};

	assign c_sel   = cls_q ? fc_q : mc_q;
	assign o_sel   = cls_q ? mc_q : fc_q;
	assign own_sel = cls_q ? ft_q : mt_q;
	assign acc_sel = cls_q ? facc_q : macc_q;
	assign cpo     = {1'b0, c_sel} + {1'b0, o_sel};
	assign n3      = {1'b0, n_q, 1'b0} + {2'b00, n_q};
	assign o10     = {1'b0, o_sel, 3'b000} + {3'b000, o_sel, 1'b0};

	// factor saturates above 48 bits; a zero divisor lands here too
	assign fsat = |(div_quot >> ACC_W);
	assign fval = fsat ? ACC_MAX : div_quot[ACC_W-1:0];
	// score update is (acc*f) >> FRAC_BITS
	assign psat = |(mul_prod >> (ACC_W + FRAC_BITS));
	assign pval = psat ? ACC_MAX : mul_prod[FRAC_BITS +: ACC_W];

	nbc_ram #(.W(2*CW), .D(CHAR_N)) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (char_q),
		.wdata (ram_wdata),
		.raddr (s_axis_tdata[AW-1:0]),
		.rdata (ram_rdata)
	);

	nbc_mul #(.W(ACC_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	nbc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			mt_q        <= '0;
			ft_q        <= '0;
			macc_q      <= '0;
			facc_q      <= '0;
			open_q      <= 1'b0;
			sat_q       <= 1'b0;
			cls_q       <= 1'b0;
			mul_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (cmd_q == CMD_TRAIN) begin
						vld_q[char_q] <= 1'b1;
						if (cnt_full || tot_full) begin
							sat_q <= 1'b1;
						end
						if (!tot_full) begin
							if (male_q) begin
								mt_q <= mt_q + 1'b1;
							end else begin
								ft_q <= ft_q + 1'b1;
							end
						end
						open_q  <= 1'b0;   // training abandons an open name
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BEGIN;
					end
				end
				S_BEGIN: begin
					cls_q <= 1'b0;
					if (open_q) begin
						state_q <= S_FACT;
					end else begin
						open_q <= 1'b1;
						if (n_q == '0) begin
							// empty model
							macc_q  <= '0;
							facc_q  <= '0;
							state_q <= S_FACT;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= S_PDIV;
						end
					end
				end
				S_PDIV: begin
					if (div_done) begin
						if (!cls_q) begin
							macc_q   <= div_quot[ACC_W-1:0];
							cls_q    <= 1'b1;
							div_go_q <= 1'b1;
						end else begin
							facc_q  <= div_quot[ACC_W-1:0];
							cls_q   <= 1'b0;
							state_q <= S_FACT;
						end
					end
				end
				S_FACT: begin
					if (c_sel != '0) begin
						mul_go_q <= 1'b1;
						state_q  <= S_M1;
					end else if (o_sel != '0) begin
						div_go_q <= 1'b1;
						state_q  <= S_FDIV;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_M1: begin
					if (mul_done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_M2;
					end
				end
				S_M2: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (div_done) begin
						if (fsat) begin
							sat_q <= 1'b1;
						end
						if (fval == ONE) begin
							state_q <= S_NEXT;
						end else begin
							mul_go_q <= 1'b1;
							state_q  <= S_APP;
						end
					end
				end
				S_APP: begin
					if (mul_done) begin
						if (psat) begin
							sat_q <= 1'b1;
						end
						if (cls_q) begin
							facc_q <= pval;
						end else begin
							macc_q <= pval;
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (!cls_q) begin
						cls_q   <= 1'b1;
						state_q <= S_FACT;
					end else if (last_q) begin
						open_q  <= 1'b0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					// wait until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and operand registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q  <= s_axis_tuser[0];
			male_q <= s_axis_tuser[1];
			last_q <= s_axis_tlast;
			char_q <= s_axis_tdata[AW-1:0];
		end
		if (state_q == S_RD) begin
			mc_q <= cur_m;
			fc_q <= cur_f;
			n_q  <= {1'b0, mt_q} + {1'b0, ft_q};
		end
		case (state_q)
			S_BEGIN: begin
				div_num_q <= NUM_W'(mt_q) << FRAC_BITS;
				div_den_q <= DEN_W'(n_q);
			end
			S_PDIV: begin
				div_num_q <= NUM_W'(ft_q) << FRAC_BITS;
			end
			S_FACT: begin
				mul_a_q   <= ACC_W'(n_q);
				mul_b_q   <= ACC_W'(c_sel);
				div_num_q <= NUM_W'(n3) << FRAC_BITS;
				div_den_q <= DEN_W'(o10);
			end
			S_M1: begin
				num_hold_q <= NUM_W'(mul_prod) << FRAC_BITS;
				mul_a_q    <= ACC_W'(own_sel);
				mul_b_q    <= ACC_W'(cpo);
			end
			S_M2: begin
				div_num_q <= num_hold_q;
				div_den_q <= DEN_W'(mul_prod);
			end
			S_FDIV: begin
				mul_a_q <= acc_sel;
				mul_b_q <= fval;
			end
			S_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_data_q <= {facc_q, macc_q};
					out_sat_q  <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// File: src/nbc_check.sv
// port-level checks for the naive bayes classifier, bound to the top level
`timescale 1ns / 1ps
module nbc_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [nbc_pkg::CHAR_W-1:0]  s_axis_tdata,
	input logic [1:0]                  s_axis_tuser,
	input logic                        s_axis_tlast,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [2*nbc_pkg::ACC_W-1:0] m_axis_tdata,
	input logic                        m_axis_tuser
);
	import nbc_pkg::*;

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// one word in flight: input closes right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// a new result only comes from a word in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared with no word in progress");
endmodule

bind char_naive_bayes_classifier nbc_check u_nbc_check (.*);
